// ----- rtl/lfd_pkg.sv -----
package lfd_pkg;

    localparam logic [31:0] MAGIC_RESET = 32'h1200_EEFF;
    localparam logic [7:0]  EXT_MARK    = 8'hFF;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FLEN,
        PH_EXT,
        PH_CONTENT,
        PH_DISCARD
    } t_phase;

    typedef enum logic [1:0] {
        CLS_HEADER,
        CLS_LENGTH,
        CLS_CONTENT,
        CLS_DISCARD
    } t_byte_class;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_MAGIC,
        ERR_OVERRUN,
        ERR_TRUNC
    } t_err;

    typedef struct packed {
        logic [7:0]  out_byte;
        t_byte_class byte_class;
        logic        length_valid;
        logic [31:0] frame_length;
        logic        frame_last;
        logic        message_last;
        t_err        error_code;
    } t_result;

endpackage

// ----- rtl/lfd_byte_if.sv -----
interface lfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- rtl/lfd_res_if.sv -----
interface lfd_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  byte_class;
    logic        length_valid;
    logic [31:0] frame_length;
    logic        frame_last;
    logic        message_last;
    logic [1:0]  error_code;

    modport source (
        output valid, output out_byte, output byte_class, output length_valid,
        output frame_length, output frame_last, output message_last,
        output error_code, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_class, input length_valid,
        input frame_length, input frame_last, input message_last,
        input error_code, output ready
    );
endinterface

// ----- rtl/lfd_cfg_if.sv -----
interface lfd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] magic_word;

    modport source (output valid, output magic_word, input ready);
    modport sink   (input valid, input magic_word, output ready);
endinterface

// ----- rtl/length_prefixed_frame_deframer.sv -----
// datapath: an accepted input word is captured in the input register, which feeds the
// result register that presents the result word
// throughput: one word per cycle, input stays ready while the result is taken
// reset: synchronous active-low i_rst_n clears parser state, sticky error and
// valid flags, and loads the magic register with its default
module length_prefixed_frame_deframer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lfd_byte_if.sink       i_byte,
    lfd_cfg_if.sink        i_cfg,
    lfd_res_if.source      o_res
);
    import lfd_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_res;
    t_result     n_res;

    logic [31:0] r_magic;
    t_phase      r_phase, n_phase;
    logic [2:0]  r_header_count, n_header_count;
    logic [31:0] r_header_shift, n_header_shift;
    logic [31:0] r_body_rem, n_body_rem;
    logic [31:0] r_ext_shift, n_ext_shift;
    logic [2:0]  r_ext_count, n_ext_count;
    logic [31:0] r_frame_rem, n_frame_rem;
    logic        r_sticky, n_sticky;

    logic        out_adv;
    logic        step;
    logic [2:0]  hdr_cnt_n;
    logic [31:0] hdr_shift_n;
    logic        magic_bad;
    logic        body_last;
    logic [31:0] ext_shift_n;
    logic [2:0]  ext_cnt_n;
    logic        ext_done;
    logic        flen_ext;
    logic        ext_short;
    logic        acc_len;
    logic [31:0] len_n;
    logic        len_over;
    logic        len_zero;
    logic        frame_end;

    // handshake
    assign out_adv       = !r_out_valid || o_res.ready;
    assign step          = r_in_valid && out_adv;
    assign i_byte.ready  = !r_in_valid || out_adv;
    assign i_cfg.ready   = 1'b1;

    // shared decode of the word in the input register
    assign hdr_cnt_n   = r_header_count + 3'd1;
    assign hdr_shift_n = {r_header_shift[23:0], r_in_byte};
    assign magic_bad   = (hdr_cnt_n == 3'd4) && (hdr_shift_n != r_magic);
    assign body_last   = (r_body_rem == 32'd1);
    assign ext_shift_n = {r_ext_shift[23:0], r_in_byte};
    assign ext_cnt_n   = r_ext_count + 3'd1;
    assign ext_done    = (ext_cnt_n >= 3'd4);
    assign flen_ext    = (r_in_byte == EXT_MARK);
    assign ext_short   = (r_body_rem < 32'd5);
    assign acc_len     = ((r_phase == PH_FLEN) && !flen_ext) ||
                         ((r_phase == PH_EXT) && ext_done);
    assign len_n       = (r_phase == PH_EXT) ? ext_shift_n : {24'd0, r_in_byte};
    // length exceeds body left after this word
    assign len_over    = (len_n >= r_body_rem);
    assign len_zero    = (len_n == 32'd0);
    assign frame_end   = (r_frame_rem == 32'd1);

    // next state
    always_comb begin
        n_phase        = r_phase;
        n_header_count = r_header_count;
        n_header_shift = r_header_shift;
        n_body_rem     = r_body_rem;
        n_ext_shift    = r_ext_shift;
        n_ext_count    = r_ext_count;
        n_frame_rem    = r_frame_rem;
        n_sticky       = r_sticky;
        if (step && !r_sticky) begin
            unique case (r_phase)
                PH_FLEN, PH_EXT: begin
                    n_body_rem = r_body_rem - 32'd1;
                    if (r_phase == PH_EXT) begin
                        n_ext_shift = ext_shift_n;
                        n_ext_count = ext_done ? 3'd0 : ext_cnt_n;
                    end
                    if (r_phase == PH_FLEN && flen_ext) begin
                        if (ext_short) begin
                            n_phase = body_last ? PH_HEADER : PH_DISCARD;
                        end else begin
                            n_ext_shift = 32'd0;
                            n_ext_count = 3'd0;
                            n_phase     = PH_EXT;
                        end
                    end else if (acc_len) begin
                        if (len_over) begin
                            n_phase = body_last ? PH_HEADER : PH_DISCARD;
                        end else if (len_zero) begin
                            n_phase = body_last ? PH_HEADER : PH_FLEN;
                        end else begin
                            n_frame_rem = len_n;
                            n_phase     = PH_CONTENT;
                        end
                    end
                end
                PH_CONTENT: begin
                    n_body_rem  = r_body_rem - 32'd1;
                    n_frame_rem = r_frame_rem - 32'd1;
                    if (frame_end) begin
                        n_phase = body_last ? PH_HEADER : PH_FLEN;
                    end
                end
                PH_DISCARD: begin
                    n_body_rem = r_body_rem - 32'd1;
                    if (body_last) begin
                        n_phase = PH_HEADER;
                    end
                end
                default: begin
                    n_phase        = PH_HEADER;
                    n_header_shift = hdr_shift_n;
                    n_header_count = hdr_cnt_n;
                    if (hdr_cnt_n == 3'd4) begin
                        n_sticky       = r_sticky || magic_bad;
                        n_header_shift = 32'd0;
                    end else if (hdr_cnt_n == 3'd0) begin
                        n_body_rem     = hdr_shift_n;
                        n_header_shift = 32'd0;
                        n_phase        = (hdr_shift_n == 32'd0) ? PH_HEADER : PH_FLEN;
                    end
                end
            endcase
        end
    end

    // result word
    always_comb begin
        n_res              = '0;
        n_res.out_byte     = r_in_byte;
        n_res.byte_class   = CLS_HEADER;
        n_res.error_code   = ERR_NONE;
        if (r_sticky) begin
            n_res.byte_class = CLS_DISCARD;
            n_res.error_code = ERR_MAGIC;
        end else begin
            unique case (r_phase)
                PH_FLEN, PH_EXT: begin
                    n_res.byte_class = CLS_LENGTH;
                    if (r_phase == PH_FLEN && flen_ext) begin
                        if (ext_short) begin
                            n_res.error_code   = ERR_TRUNC;
                            n_res.message_last = body_last;
                        end
                    end else if (acc_len) begin
                        if (len_over) begin
                            n_res.error_code   = ERR_OVERRUN;
                            n_res.message_last = body_last;
                        end else begin
                            n_res.length_valid = 1'b1;
                            n_res.frame_length = len_n;
                            n_res.frame_last   = len_zero;
                            n_res.message_last = len_zero && body_last;
                        end
                    end
                end
                PH_CONTENT: begin
                    n_res.byte_class   = CLS_CONTENT;
                    n_res.frame_last   = frame_end;
                    n_res.message_last = frame_end && body_last;
                end
                PH_DISCARD: begin
                    n_res.byte_class   = CLS_DISCARD;
                    n_res.message_last = body_last;
                end
                default: begin
                    n_res.byte_class   = CLS_HEADER;
                    n_res.error_code   = magic_bad ? ERR_MAGIC : ERR_NONE;
                    n_res.message_last = (hdr_cnt_n == 3'd0) && (hdr_shift_n == 32'd0);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_magic        <= MAGIC_RESET;
            r_phase        <= PH_HEADER;
            r_header_count <= 3'd0;
            r_header_shift <= 32'd0;
            r_body_rem     <= 32'd0;
            r_ext_shift    <= 32'd0;
            r_ext_count    <= 3'd0;
            r_frame_rem    <= 32'd0;
            r_sticky       <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_magic <= i_cfg.magic_word;
            end
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
            r_phase        <= n_phase;
            r_header_count <= n_header_count;
            r_header_shift <= n_header_shift;
            r_body_rem     <= n_body_rem;
            r_ext_shift    <= n_ext_shift;
            r_ext_count    <= n_ext_count;
            r_frame_rem    <= n_frame_rem;
            r_sticky       <= n_sticky;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.data_byte;
        end
        if (step) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_byte     = r_res.out_byte;
    assign o_res.byte_class   = r_res.byte_class;
    assign o_res.length_valid = r_res.length_valid;
    assign o_res.frame_length = r_res.frame_length;
    assign o_res.frame_last   = r_res.frame_last;
    assign o_res.message_last = r_res.message_last;
    assign o_res.error_code   = r_res.error_code;

endmodule

// ----- rtl/lfd_checker.sv -----
module lfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  i_out_byte,
    input logic [1:0]  i_byte_class,
    input logic        i_length_valid,
    input logic [31:0] i_frame_length,
    input logic [1:0]  i_error_code
);
    import lfd_pkg::*;

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("stalled word changed");

    a_length_on_length_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_length_valid |->
            (i_byte_class == CLS_LENGTH) && (i_error_code == ERR_NONE))
        else $error("length mark on wrong word");

    a_length_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_length_valid |-> (i_frame_length == 32'd0))
        else $error("frame length without mark");

    a_magic_err_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_error_code == ERR_MAGIC) |->
            (i_byte_class == CLS_HEADER) || (i_byte_class == CLS_DISCARD))
        else $error("magic error on body word");

endmodule

bind length_prefixed_frame_deframer lfd_checker u_lfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_byte     (o_res.out_byte),
    .i_byte_class   (o_res.byte_class),
    .i_length_valid (o_res.length_valid),
    .i_frame_length (o_res.frame_length),
    .i_error_code   (o_res.error_code)
);
